/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/gddn_pkg.sv */
// ---------------------------------------------------------------------------
// gddn_pkg
// Calendar constants, month tables and shared types for the date pipeline.
// ---------------------------------------------------------------------------
package gddn_pkg;

  localparam int EPOCH_YEAR = 1970;
  localparam int MAX_YEAR   = 9999;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFS_W    = 10;
  localparam int ORD_W    = 9;
  localparam int DAYS_W   = 22;
  localparam int WD_W     = 3;
  localparam int Q100_W   = 8;
  localparam int LEAPS_W  = 12;

  // floor(y / 100) = floor((y >> 2) * 5243 >> 17) for every 14-bit y
  localparam int DIV100_MULT  = 5243;
  localparam int DIV100_SHIFT = 17;

  // floor(d / 7) = (d * 4793491) >> 25 for d below 6.7 million
  localparam int DIV7_MULT  = 4793491;
  localparam int DIV7_SHIFT = 25;

  localparam int DAYS_YEAR = 365;
  localparam int DAYS_LEAP = 366;

  // Leap years in 1 .. EPOCH_YEAR-1
  localparam int EPOCH_LEAPS = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                               + (EPOCH_YEAR - 1) / 400;
  localparam int LEAPS_1600  = 1600 / 4 - 1600 / 100 + 1600 / 400;
  // 1601-01-01 was a Monday
  localparam int EPOCH_BASE  = (EPOCH_YEAR - 1601) * 365 + EPOCH_LEAPS - LEAPS_1600;
  localparam int EPOCH_WD0   = (1 + EPOCH_BASE) % 7;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic                 valid;
    logic                 leap;
    logic [ORD_W-1:0]     ordinal;
    logic [LEAPS_W-1:0]   leaps_prev;
  } date_info_t;

  // Days in a common-year month; 0 for codes that are not months
  function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of month m, with the leap day after February
  function automatic logic [ORD_W-1:0] month_start_f(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [ORD_W-1:0] start;
    unique case (m)
      4'd1:    start = 9'd0;
      4'd2:    start = 9'd31;
      4'd3:    start = 9'd59;
      4'd4:    start = 9'd90;
      4'd5:    start = 9'd120;
      4'd6:    start = 9'd151;
      4'd7:    start = 9'd181;
      4'd8:    start = 9'd212;
      4'd9:    start = 9'd243;
      4'd10:   start = 9'd273;
      4'd11:   start = 9'd304;
      4'd12:   start = 9'd334;
      default: start = 9'd0;
    endcase
    if (leap && (m > MON_FEB) && (m <= MON_DEC)) begin
      start = start + 9'd1;
    end
    return start;
  endfunction

endpackage

/* sv/gddn_date_check.sv */
// ---------------------------------------------------------------------------
// gddn_date_check
// Leap-year test, date validity, day of year and leap count before the year.
// ---------------------------------------------------------------------------
module gddn_date_check (
  input  logic [gddn_pkg::YEAR_W-1:0]  year,
  input  logic [gddn_pkg::MONTH_W-1:0] month,
  input  logic [gddn_pkg::DAY_W-1:0]   day,
  input  logic [gddn_pkg::Q100_W-1:0]  q100,
  output gddn_pkg::date_info_t         info
);

  logic                             div4;
  logic                             div100;
  logic                             div400;
  logic                             leap;
  logic [gddn_pkg::DAY_W:0]         len;
  logic                             valid;
  logic [gddn_pkg::YEAR_W-1:0]      hundreds;
  logic [gddn_pkg::LEAPS_W-1:0]     leaps_incl;

  assign hundreds = gddn_pkg::YEAR_W'({6'd0, q100} * 14'd100);
  assign div4     = (year[1:0] == 2'd0);
  assign div100   = (year == hundreds);
  assign div400   = div100 && (q100[1:0] == 2'd0);
  assign leap     = (div4 && !div100) || div400;

  assign len = {1'b0, gddn_pkg::month_len_f(month)}
             + {5'd0, (month == gddn_pkg::MON_FEB) && leap};

  assign valid = (year <= gddn_pkg::YEAR_W'(gddn_pkg::MAX_YEAR))
              && (month >= gddn_pkg::MON_JAN) && (month <= gddn_pkg::MON_DEC)
              && (day != 5'd0) && ({1'b0, day} <= len);

  // Leap years in 1 .. year, then drop this year's own
  assign leaps_incl = year[13:2] - gddn_pkg::LEAPS_W'(q100)
                    + gddn_pkg::LEAPS_W'(q100[7:2]);

  always_comb begin
    info.valid      = valid;
    info.leap       = leap;
    info.ordinal    = valid ? gddn_pkg::month_start_f(month, leap) + 9'(day) : 9'd0;
    info.leaps_prev = leaps_incl - gddn_pkg::LEAPS_W'(leap);
  end

endmodule

/* sv/gregorian_date_day_number.sv */
// ---------------------------------------------------------------------------
// gregorian_date_day_number
// Gregorian date check, day of year, days since epoch, weekday and an
// in-year day shift.
// ---------------------------------------------------------------------------
// Takes one date per clock while in_stall is low. The data passes five
// register stages: input register, year/100 reciprocal multiply, date check,
// epoch count and month search, then weekday by reciprocal multiply mod 7
// into the output register. The pipeline stalls as a whole only while a
// result sits in the output register and out_stall is high; otherwise
// in_stall is low and a new date enters every cycle.
`include "assert_macros.svh"

module gregorian_date_day_number (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gddn_pkg::YEAR_W-1:0]         in_year,
  input  logic [gddn_pkg::MONTH_W-1:0]        in_month,
  input  logic [gddn_pkg::DAY_W-1:0]          in_day,
  input  logic signed [gddn_pkg::OFS_W-1:0]   in_day_offset,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_date_valid,
  output logic                                out_epoch_ok,
  output logic [gddn_pkg::ORD_W-1:0]          out_ordinal_day,
  output logic [gddn_pkg::DAYS_W-1:0]         out_days_since_epoch,
  output logic [gddn_pkg::WD_W-1:0]           out_weekday,
  output logic                                out_shift_ok,
  output logic [gddn_pkg::MONTH_W-1:0]        out_new_month,
  output logic [gddn_pkg::DAY_W-1:0]          out_new_day
);

  logic advance;

  // Stage valids
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;

  // Stage 1: registered inputs
  logic [gddn_pkg::YEAR_W-1:0]        s1_year_r;
  logic [gddn_pkg::MONTH_W-1:0]       s1_month_r;
  logic [gddn_pkg::DAY_W-1:0]         s1_day_r;
  logic signed [gddn_pkg::OFS_W-1:0]  s1_ofs_r;

  // Stage 2: year / 100
  logic [24:0]                        q_prod;
  logic [gddn_pkg::YEAR_W-1:0]        s2_year_r;
  logic [gddn_pkg::MONTH_W-1:0]       s2_month_r;
  logic [gddn_pkg::DAY_W-1:0]         s2_day_r;
  logic signed [gddn_pkg::OFS_W-1:0]  s2_ofs_r;
  logic [gddn_pkg::Q100_W-1:0]        s2_q100_r;

  // Stage 3: date check
  gddn_pkg::date_info_t               info;
  gddn_pkg::date_info_t               s3_info_r;
  logic                               s3_after_epoch_r;
  logic [gddn_pkg::YEAR_W-1:0]        s3_year_ofs_r;
  logic [gddn_pkg::MONTH_W-1:0]       s3_month_r;
  logic [gddn_pkg::DAY_W-1:0]         s3_day_r;
  logic signed [gddn_pkg::OFS_W-1:0]  s3_ofs_r;

  // Stage 4: epoch count and shift
  logic [22:0]                        days_full;
  logic                               epoch_nxt;
  logic signed [10:0]                 target;
  logic [8:0]                         target_u;
  logic [8:0]                         limit;
  logic                               shift_nxt;
  logic [gddn_pkg::MONTH_W-1:0]       nm_nxt;
  logic [gddn_pkg::DAY_W-1:0]         nd_nxt;
  logic                               s4_valid_r;
  logic                               s4_epoch_r;
  logic [gddn_pkg::ORD_W-1:0]         s4_ordinal_r;
  logic [gddn_pkg::DAYS_W-1:0]        s4_days_r;
  logic                               s4_shift_r;
  logic [gddn_pkg::MONTH_W-1:0]       s4_nm_r;
  logic [gddn_pkg::DAY_W-1:0]         s4_nd_r;

  // Stage 5: weekday
  logic [22:0]                        wd_sum;
  logic [45:0]                        wd_prod;
  logic [22:0]                        wd_rem;
  logic [gddn_pkg::WD_W-1:0]          wd_nxt;

  logic                               out_date_valid_r;
  logic                               out_epoch_ok_r;
  logic [gddn_pkg::ORD_W-1:0]         out_ordinal_r;
  logic [gddn_pkg::DAYS_W-1:0]        out_days_r;
  logic [gddn_pkg::WD_W-1:0]          out_weekday_r;
  logic                               out_shift_ok_r;
  logic [gddn_pkg::MONTH_W-1:0]       out_new_month_r;
  logic [gddn_pkg::DAY_W-1:0]         out_new_day_r;

  // Hold everything only while the output transaction is blocked
  assign advance  = !(out_v_r && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // ---- stage 2 logic
  assign q_prod = 25'(s1_year_r[13:2]) * 25'(gddn_pkg::DIV100_MULT);

  // ---- stage 3 logic
  gddn_date_check u_check (
    .year  (s2_year_r),
    .month (s2_month_r),
    .day   (s2_day_r),
    .q100  (s2_q100_r),
    .info  (info)
  );

  // ---- stage 4 logic
  assign days_full = 23'(s3_year_ofs_r) * 23'(gddn_pkg::DAYS_YEAR)
                   + 23'(s3_info_r.leaps_prev) - 23'(gddn_pkg::EPOCH_LEAPS)
                   + 23'(s3_info_r.ordinal) - 23'd1;
  assign epoch_nxt = s3_info_r.valid && s3_after_epoch_r;

  assign target   = $signed({2'b00, s3_info_r.ordinal}) + 11'(s3_ofs_r);
  assign target_u = target[8:0];
  assign limit    = s3_info_r.leap ? 9'(gddn_pkg::DAYS_LEAP) : 9'(gddn_pkg::DAYS_YEAR);
  assign shift_nxt = s3_info_r.valid && (target >= 11'sd1)
                  && (target <= $signed({2'b00, limit}));

  always_comb begin
    logic [gddn_pkg::MONTH_W-1:0] mon;
    mon = gddn_pkg::MON_JAN;
    // Last month whose first day lies at or before the target
    for (int i = 2; i <= 12; i++) begin
      if (target_u > gddn_pkg::month_start_f(4'(i), s3_info_r.leap)) begin
        mon = 4'(i);
      end
    end
    nm_nxt = shift_nxt ? mon : s3_month_r;
    nd_nxt = shift_nxt ? 5'(target_u - gddn_pkg::month_start_f(mon, s3_info_r.leap))
                       : s3_day_r;
  end

  // ---- stage 5 logic
  assign wd_sum  = 23'(s4_days_r) + 23'(gddn_pkg::EPOCH_WD0);
  assign wd_prod = 46'(wd_sum) * 46'(gddn_pkg::DIV7_MULT);
  assign wd_rem  = wd_sum - 23'(wd_prod[45:gddn_pkg::DIV7_SHIFT]) * 23'd7;
  assign wd_nxt  = s4_epoch_r ? wd_rem[2:0] : 3'd0;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_year_r  <= in_year;
      s1_month_r <= in_month;
      s1_day_r   <= in_day;
      s1_ofs_r   <= in_day_offset;

      s2_year_r  <= s1_year_r;
      s2_month_r <= s1_month_r;
      s2_day_r   <= s1_day_r;
      s2_ofs_r   <= s1_ofs_r;
      s2_q100_r  <= q_prod[gddn_pkg::DIV100_SHIFT +: gddn_pkg::Q100_W];

      s3_info_r        <= info;
      s3_after_epoch_r <= (s2_year_r >= gddn_pkg::YEAR_W'(gddn_pkg::EPOCH_YEAR));
      s3_year_ofs_r    <= s2_year_r - gddn_pkg::YEAR_W'(gddn_pkg::EPOCH_YEAR);
      s3_month_r       <= s2_month_r;
      s3_day_r         <= s2_day_r;
      s3_ofs_r         <= s2_ofs_r;

      s4_valid_r   <= s3_info_r.valid;
      s4_epoch_r   <= epoch_nxt;
      s4_ordinal_r <= s3_info_r.ordinal;
      s4_days_r    <= epoch_nxt ? days_full[gddn_pkg::DAYS_W-1:0] : '0;
      s4_shift_r   <= shift_nxt;
      s4_nm_r      <= nm_nxt;
      s4_nd_r      <= nd_nxt;

      out_date_valid_r <= s4_valid_r;
      out_epoch_ok_r   <= s4_epoch_r;
      out_ordinal_r    <= s4_ordinal_r;
      out_days_r       <= s4_days_r;
      out_weekday_r    <= wd_nxt;
      out_shift_ok_r   <= s4_shift_r;
      out_new_month_r  <= s4_nm_r;
      out_new_day_r    <= s4_nd_r;
    end
  end

  assign out_valid            = out_v_r;
  assign out_date_valid       = out_date_valid_r;
  assign out_epoch_ok         = out_epoch_ok_r;
  assign out_ordinal_day      = out_ordinal_r;
  assign out_days_since_epoch = out_days_r;
  assign out_weekday          = out_weekday_r;
  assign out_shift_ok         = out_shift_ok_r;
  assign out_new_month        = out_new_month_r;
  assign out_new_day          = out_new_day_r;

  // ---- assertions
  `ASSERT_CLKD(a_epoch_needs_valid, clk, rst_n, out_valid && out_epoch_ok |-> out_date_valid, "epoch result on invalid date")
  `ASSERT_CLKD(a_shift_in_range, clk, rst_n, out_valid && out_shift_ok |-> out_date_valid && out_new_month >= gddn_pkg::MON_JAN && out_new_month <= gddn_pkg::MON_DEC && out_new_day != 5'd0, "shifted date out of range")
  `ASSERT_CLKD(a_no_epoch_zero, clk, rst_n, out_valid && !out_epoch_ok |-> out_days_since_epoch == '0 && out_weekday == 3'd0, "epoch fields not cleared")
  `ASSERT_CLKD(a_weekday_range, clk, rst_n, out_valid |-> out_weekday < 3'd7, "weekday out of range")
  `ASSERT_CLKD(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without a blocked output")

endmodule
